FILE: sv/cds_pkg.sv
// Package for the change dispenser: field widths, mode codes, the
// sequencer status/control structs and the denomination tables.
// No dependencies.
package cds_pkg;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int ITEM_W   = 4;
	localparam int AMT_W    = 16;
	localparam int DSEL_W   = 4;
	localparam int CNT_W    = 8;
	localparam int DVAL_W   = 9;
	localparam int RECIP_W  = 26;
	localparam int RECIP_SH = 25;
	localparam int PROD_W   = AMT_W + RECIP_W;

	// Input word modes
	localparam logic [MODE_W-1:0] MODE_BUY   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PRICE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STOCK = 2'd2;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic start;     // purchase word taken this cycle
		logic under;     // paid amount below price
		logic more;      // denominations left after the current one
		logic out_free;  // output register can take a word
	} seq_stat_t;

	// Control word fields driven into the datapath
	typedef struct packed {
		logic accept;
		logic ld_left;
		logic ld_n;
		logic emit_pay;
		logic emit_under;
	} seq_ctrl_t;

	// Denomination value in cents; unused slots are worth nothing
	function automatic logic [DVAL_W-1:0] denom_cents(input logic [DSEL_W-1:0] i);
		logic [DVAL_W-1:0] v;
		case (i)
			4'd0:    v = 9'd500;
			4'd1:    v = 9'd200;
			4'd2:    v = 9'd100;
			4'd3:    v = 9'd50;
			4'd4:    v = 9'd20;
			4'd5:    v = 9'd10;
			4'd6:    v = 9'd5;
			4'd7:    v = 9'd2;
			4'd8:    v = 9'd1;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// ceil(2^25 / value): exact quotient for any 16-bit dividend
	function automatic logic [RECIP_W-1:0] denom_recip(input logic [DSEL_W-1:0] i);
		logic [RECIP_W-1:0] r;
		case (i)
			4'd0:    r = 26'd67109;
			4'd1:    r = 26'd167773;
			4'd2:    r = 26'd335545;
			4'd3:    r = 26'd671089;
			4'd4:    r = 26'd1677722;
			4'd5:    r = 26'd3355444;
			4'd6:    r = 26'd6710887;
			4'd7:    r = 26'd16777216;
			4'd8:    r = 26'd33554432;
			default: r = 26'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/cds_in_if.sv
// Request channel of the change dispenser: purchase and load words.
// Depends on cds_pkg for field widths.
interface cds_in_if;
	import cds_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ITEM_W-1:0]   item_choice;
	logic [AMT_W-1:0]    amount;
	logic [DSEL_W-1:0]   denom_select;

	modport source (output valid, mode, item_choice, amount, denom_select, input ready);
	modport sink   (input valid, mode, item_choice, amount, denom_select, output ready);
endinterface

FILE: sv/cds_out_if.sv
// Result channel of the change dispenser: one word per denomination from the start one, or a single underpaid word.
// Depends on cds_pkg for field widths.
interface cds_out_if;
	import cds_pkg::*;
	logic                valid;
	logic                ready;
	logic [DSEL_W-1:0]   denom_index;
	logic [CNT_W-1:0]    coin_count;
	logic [AMT_W-1:0]    total_returned;
	logic [AMT_W-1:0]    change_left;
	logic                underpaid;
	logic                last;

	modport source (output valid, denom_index, coin_count, total_returned, change_left,
		underpaid, last, input ready);
	modport sink   (input valid, denom_index, coin_count, total_returned, change_left,
		underpaid, last, output ready);
endinterface

FILE: sv/cds_cfg_if.sv
// Configuration write channel: carries the stock limiting enable.
// No dependencies.
interface cds_cfg_if;
	logic valid;
	logic ready;
	logic limit_by_stock;

	modport source (output valid, limit_by_stock, input ready);
	modport sink   (input valid, limit_by_stock, output ready);
endinterface

FILE: sv/cds_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on cds_pkg for the status and control structs.
module cds_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  cds_pkg::seq_stat_t  stat,
	output cds_pkg::seq_ctrl_t  ctrl
);
	import cds_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_LOOKUP, S_DIV, S_PAY, S_UNDER} step_t;
	typedef enum logic [1:0] {C_NONE, C_START, C_UNDER, C_MORE} cond_t;

	typedef struct packed {
		seq_ctrl_t ctl;
		cond_t     cond;
		step_t     jmp;
		step_t     nxt;
	} uword_t;

	// Control program
	function automatic uword_t urom(input step_t s);
		uword_t u;
		u = '0;
		case (s)
			S_IDLE: begin
				u.ctl.accept = 1'b1;
				u.cond = C_START;
				u.jmp  = S_LOOKUP;
				u.nxt  = S_IDLE;
			end
			S_LOOKUP: begin
				u.ctl.ld_left = 1'b1;
				u.cond = C_UNDER;
				u.jmp  = S_UNDER;
				u.nxt  = S_DIV;
			end
			S_DIV: begin
				u.ctl.ld_n = 1'b1;
				u.cond = C_NONE;
				u.jmp  = S_IDLE;
				u.nxt  = S_PAY;
			end
			S_PAY: begin
				u.ctl.emit_pay = 1'b1;
				u.cond = C_MORE;
				u.jmp  = S_DIV;
				u.nxt  = S_IDLE;
			end
			S_UNDER: begin
				u.ctl.emit_under = 1'b1;
				u.cond = C_NONE;
				u.jmp  = S_IDLE;
				u.nxt  = S_IDLE;
			end
			default: begin
				u.ctl.accept = 1'b1;
				u.cond = C_START;
				u.jmp  = S_LOOKUP;
				u.nxt  = S_IDLE;
			end
		endcase
		return u;
	endfunction

	step_t  step_q;
	uword_t uw;
	logic   take;
	logic   hold;

	// Decode current word, pick the jump, stall on a full output register
	always_comb begin
		uw = urom(step_q);
		case (uw.cond)
			C_START: take = stat.start;
			C_UNDER: take = stat.under;
			C_MORE:  take = stat.more;
			default: take = 1'b0;
		endcase
		hold = (uw.ctl.emit_pay | uw.ctl.emit_under) & ~stat.out_free;
		ctrl = uw.ctl;
		ctrl.emit_pay   = uw.ctl.emit_pay & stat.out_free;
		ctrl.emit_under = uw.ctl.emit_under & stat.out_free;
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (!hold) begin
			step_q <= take ? uw.jmp : uw.nxt;
		end
	end

endmodule

FILE: sv/change_dispenser_with_stock_top.sv
// Change dispenser top level: price memory, coin stock, divide-by-constant
// datapath and output register. Depends on cds_pkg, the three channel
// interfaces and cds_seq.
// Sequence: a purchase word is taken while idle, then goes through a price
//   lookup and, per denomination, a reciprocal multiply and a pay step; an
//   underpaid purchase goes from the lookup to a single underpaid word. A
//   result waits while the output register is full. No new word is taken
//   until a purchase is through; load words are taken back to back while idle.
// Reset: stock clears to zero, prices read as zero, stock limiting is on.
module change_dispenser_with_stock_top #(
	parameter int NUM_DENOMS = 9,
	parameter int NUM_ITEMS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cds_in_if.sink      req,
	cds_out_if.source   rsp,
	cds_cfg_if.sink     cfg
);
	import cds_pkg::*;

	localparam int SAW = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
	localparam int IAW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
	localparam logic [DSEL_W-1:0] LAST_IDX = DSEL_W'(NUM_DENOMS - 1);

	seq_stat_t stat;
	seq_ctrl_t ctrl;

	logic                limit_q;
	logic [CNT_W-1:0]    stock_q [NUM_DENOMS];
	logic [AMT_W-1:0]    price_mem [NUM_ITEMS];
	logic                pvalid_q [NUM_ITEMS];
	logic [AMT_W-1:0]    price_rd_q;
	logic                price_hit_q;
	logic [AMT_W-1:0]    amount_q;
	logic [DSEL_W-1:0]   idx_q;
	logic [AMT_W-1:0]    left_q;
	logic [AMT_W-1:0]    total_q;
	logic [CNT_W-1:0]    n_q;

	logic                out_valid_q;
	logic [DSEL_W-1:0]   out_denom_q;
	logic [CNT_W-1:0]    out_count_q;
	logic [AMT_W-1:0]    out_total_q;
	logic [AMT_W-1:0]    out_left_q;
	logic                out_under_q;
	logic                out_last_q;

	logic                take;
	logic                item_ok;
	logic                dsel_ok;
	logic [IAW-1:0]      item_addr;
	logic [SAW-1:0]      load_addr;
	logic [SAW-1:0]      cur_addr;
	logic [AMT_W-1:0]    price;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-RECIP_SH-1:0] quo;
	logic [CNT_W-1:0]    qcap;
	logic [CNT_W-1:0]    stock_rd;
	logic [CNT_W-1:0]    n_next;
	logic [CNT_W+DVAL_W-1:0] pay_full;
	logic [AMT_W-1:0]    pay;

	// Sequencer
	cds_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Request decode
	assign req.ready = ctrl.accept;
	assign cfg.ready = 1'b1;
	assign take      = req.valid & ctrl.accept;
	assign item_ok   = 32'(req.item_choice) < NUM_ITEMS;
	assign dsel_ok   = 32'(req.denom_select) < NUM_DENOMS;
	assign item_addr = IAW'(req.item_choice);
	assign load_addr = SAW'(req.denom_select);
	assign cur_addr  = SAW'(idx_q);

	// Price lookup and greedy step arithmetic
	always_comb begin
		price    = price_hit_q ? price_rd_q : '0;
		stock_rd = stock_q[cur_addr];
		prod     = PROD_W'(left_q) * PROD_W'(denom_recip(idx_q));
		quo      = prod[PROD_W-1:RECIP_SH];
		qcap     = (quo > (PROD_W-RECIP_SH)'(255)) ? CNT_W'(255) : quo[CNT_W-1:0];
		n_next   = (limit_q && (stock_rd < qcap)) ? stock_rd : qcap;
		pay_full = (CNT_W+DVAL_W)'(n_q) * (CNT_W+DVAL_W)'(denom_cents(idx_q));
		pay      = pay_full[AMT_W-1:0];
	end

	// Sequencer status
	always_comb begin
		stat.start    = take & (req.mode == MODE_BUY);
		stat.under    = amount_q < price;
		stat.more     = idx_q != LAST_IDX;
		stat.out_free = ~out_valid_q | rsp.ready;
	end

	// Stock limiting register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 1'b1;
		end else if (cfg.valid) begin
			limit_q <= cfg.limit_by_stock;
		end
	end

	// Coin stock: loaded by stock words, drawn down at each pay step while stock limiting is on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DENOMS; i++) begin
				stock_q[i] <= '0;
			end
		end else if (take && req.mode == MODE_STOCK && dsel_ok) begin
			stock_q[load_addr] <= req.amount[CNT_W-1:0];
		end else if (ctrl.emit_pay && limit_q) begin
			stock_q[cur_addr] <= stock_q[cur_addr] - n_q;
		end
	end

	// Price valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ITEMS; i++) begin
				pvalid_q[i] <= 1'b0;
			end
		end else if (take && req.mode == MODE_PRICE && item_ok) begin
			pvalid_q[item_addr] <= 1'b1;
		end
	end

	// Price memory, registered read on the purchase word
	always_ff @(posedge clk) begin
		if (take && req.mode == MODE_PRICE && item_ok) begin
			price_mem[item_addr] <= req.amount;
		end
		if (take) begin
			price_rd_q  <= price_mem[item_addr];
			price_hit_q <= item_ok && pvalid_q[item_addr];
		end
	end

	// Purchase working registers
	always_ff @(posedge clk) begin
		if (take) begin
			amount_q <= req.amount;
			idx_q    <= dsel_ok ? req.denom_select : '0;
		end
		if (ctrl.ld_left) begin
			left_q  <= amount_q - price;
			total_q <= '0;
		end
		if (ctrl.ld_n) begin
			n_q <= n_next;
		end
		if (ctrl.emit_pay) begin
			left_q  <= left_q - pay;
			total_q <= total_q + pay;
			idx_q   <= idx_q + 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit_pay || ctrl.emit_under) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctrl.emit_pay) begin
			out_denom_q <= idx_q;
			out_count_q <= n_q;
			out_total_q <= total_q + pay;
			out_left_q  <= left_q - pay;
			out_under_q <= 1'b0;
			out_last_q  <= ~stat.more;
		end else if (ctrl.emit_under) begin
			out_denom_q <= '0;
			out_count_q <= '0;
			out_total_q <= '0;
			out_left_q  <= '0;
			out_under_q <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.denom_index    = out_denom_q;
	assign rsp.coin_count     = out_count_q;
	assign rsp.total_returned = out_total_q;
	assign rsp.change_left    = out_left_q;
	assign rsp.underpaid      = out_under_q;
	assign rsp.last           = out_last_q;

	// Checks
	a_buy_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		stat.start |=> ctrl.ld_left)
		else $error("purchase word not followed by price lookup");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit_pay || ctrl.emit_under) |-> (!out_valid_q || rsp.ready))
		else $error("result overwrote a pending word");

	a_stock_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit_pay && limit_q) |-> (n_q <= stock_q[cur_addr]))
		else $error("coin count exceeds stock");

	a_left_falls: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit_pay |=> (left_q <= $past(left_q)))
		else $error("change owed grew during payout");

	a_under_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_under_q) |-> (out_last_q && out_count_q == '0))
		else $error("underpaid word malformed");

endmodule

FILE: bench/tb_change_dispenser_with_stock_top.sv
`timescale 1ns / 100ps
// Testbench for change_dispenser_with_stock_top: random and directed purchase,
// price and stock words, checked against an in-bench change predictor.
// Depends on cds_pkg, the three channel interfaces and the RTL top.
module tb_change_dispenser_with_stock_top;
	import cds_pkg::*;

	localparam int N_DENOMS       = 9;
	localparam int N_ARTICLES     = 16;
	localparam int CNT_CAP        = 255;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_WORDS    = 60;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam int unsigned COIN_CENTS [N_DENOMS] = '{500, 200, 100, 50, 20, 10, 5, 2, 1};

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ITEM_W-1:0] item;
		logic [AMT_W-1:0]  amount;
		logic [DSEL_W-1:0] dsel;
	} req_word_t;

	typedef struct packed {
		logic [DSEL_W-1:0] denom;
		logic [CNT_W-1:0]  count;
		logic [AMT_W-1:0]  total;
		logic [AMT_W-1:0]  left;
		logic              under;
		logic              last;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cds_in_if  req_if ();
	cds_out_if rsp_if ();
	cds_cfg_if cfg_if ();

	change_dispenser_with_stock_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Predictor state: limiting mode, coin stock, price list
	logic             limit_on;
	logic [CNT_W-1:0] coins_on_hand [N_DENOMS];
	logic [AMT_W-1:0] article_price [N_ARTICLES];

	// Stimulus side: price shadow used only to shape purchase amounts
	int unsigned price_plan [N_ARTICLES];
	req_word_t   pending_words [$];
	rsp_word_t   change_due [$];
	req_word_t   on_bus;

	int unsigned words_queued, words_taken, words_checked;
	int unsigned n_buys, n_under, n_loads, mismatches;
	int unsigned tx_gap, rx_gap, idle_cycles;
	bit          tx_steady, rx_steady, hold_armed;
	logic        hold_off;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length: mostly none or short, a few long; none in steady stretches
	function automatic int unsigned pick_gap(bit steady);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one accepted word to the predictor and queue the change words it yields
	task automatic compute_change(input req_word_t w);
		int unsigned price, start, left, total, n, d;
		int i;
		rsp_word_t r;
		case (w.mode)
			MODE_PRICE: begin
				n_loads++;
				if (w.item < N_ARTICLES)
					article_price[w.item] = w.amount;
			end
			MODE_STOCK: begin
				n_loads++;
				if (w.dsel < N_DENOMS)
					coins_on_hand[w.dsel] = w.amount[CNT_W-1:0];
			end
			MODE_BUY: begin
				n_buys++;
				price = (w.item < N_ARTICLES) ? article_price[w.item] : 0;
				start = (w.dsel < N_DENOMS) ? w.dsel : 0;
				if (w.amount < price) begin
					n_under++;
					r = '0;
					r.under = 1'b1;
					r.last = 1'b1;
					change_due.push_back(r);
				end else begin
					left = w.amount - price;
					total = 0;
					for (i = start; i < N_DENOMS; i++) begin
						d = COIN_CENTS[i];
						n = left / d;
						if (n > CNT_CAP)
							n = CNT_CAP;
						if (limit_on) begin
							if (n > coins_on_hand[i])
								n = coins_on_hand[i];
							coins_on_hand[i] = coins_on_hand[i] - n[CNT_W-1:0];
						end
						left = left - n * d;
						total = total + n * d;
						r.denom = i[DSEL_W-1:0];
						r.count = n[CNT_W-1:0];
						r.total = total[AMT_W-1:0];
						r.left = left[AMT_W-1:0];
						r.under = 1'b0;
						r.last = (i == N_DENOMS - 1);
						change_due.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic string show_word(rsp_word_t w);
		return $sformatf("denom %0d coins %0d total %0d left %0d under %0b last %0b",
			w.denom, w.count, w.total, w.left, w.under, w.last);
	endfunction

	task automatic flag_mismatch(input string why, input string want_txt, input rsp_word_t got);
		if (mismatches < 10)
			$display("%0t %s: expected %s, got %s", $time, why, want_txt, show_word(got));
		mismatches++;
	endtask

	// Queue a request word; track queued prices for amount shaping
	task automatic queue_word(input logic [MODE_W-1:0] mode, input int unsigned item,
			input int unsigned amount, input int unsigned dsel);
		req_word_t w;
		w.mode = mode;
		w.item = item[ITEM_W-1:0];
		w.amount = amount[AMT_W-1:0];
		w.dsel = dsel[DSEL_W-1:0];
		if (mode == MODE_PRICE)
			price_plan[w.item] = w.amount;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Mostly purchases near the price plus stock refills; some noise
	task automatic queue_random_word();
		int unsigned pick, item, pay, dsel;
		pick = $urandom_range(0, 99);
		item = $urandom_range(0, N_ARTICLES - 1);
		dsel = $urandom_range(0, 15);
		if (pick < 55) begin
			if ($urandom_range(0, 3) != 0)
				dsel = ($urandom_range(0, 2) == 0) ? $urandom_range(0, N_DENOMS - 1) : 0;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				pay = price_plan[item] + $urandom_range(0, 1200);
				if (pay > 65535)
					pay = 65535;
			end else if (pick < 9 || price_plan[item] == 0)
				pay = $urandom_range(0, 65535);
			else
				pay = price_plan[item] - 1;
			queue_word(MODE_BUY, item, pay, dsel);
		end else if (pick < 80) begin
			if ($urandom_range(0, 9) != 0)
				dsel = $urandom_range(0, N_DENOMS - 1);
			queue_word(MODE_STOCK, item, $urandom_range(0, 65535), dsel);
		end else if (pick < 95) begin
			queue_word(MODE_PRICE, item,
				($urandom_range(0, 9) < 7) ? $urandom_range(0, 3000) : $urandom_range(0, 65535),
				dsel);
		end else
			queue_word(MODE_SPARE, item, $urandom_range(0, 65535), dsel);
	endtask

	// Block until every queued word is taken and all change words are back
	task automatic wait_idle();
		while (words_taken != words_queued || change_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_stock_limiting(input logic on);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.limit_by_stock <= on;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		limit_on = on;
	endtask

	// Request driver: one word on the bus at a time, random gaps between words
	always @(posedge clk) begin : driver
		logic nxt_valid;
		nxt_valid = req_if.valid;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				compute_change(on_bus);
				words_taken++;
				tx_gap = pick_gap(tx_steady);
				if ($urandom_range(0, 29) == 0)
					tx_steady = !tx_steady;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (tx_gap != 0)
					tx_gap--;
				else if (pending_words.size() != 0) begin
					on_bus = pending_words.pop_front();
					req_if.mode <= on_bus.mode;
					req_if.item_choice <= on_bus.item;
					req_if.amount <= on_bus.amount;
					req_if.denom_select <= on_bus.dsel;
					nxt_valid = 1'b1;
				end
			end
		end
		req_if.valid <= nxt_valid;
	end

	// Result monitor and receiver stalls
	always @(posedge clk) begin : monitor
		rsp_word_t got, want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.denom = rsp_if.denom_index;
			got.count = rsp_if.coin_count;
			got.total = rsp_if.total_returned;
			got.left = rsp_if.change_left;
			got.under = rsp_if.underpaid;
			got.last = rsp_if.last;
			words_checked++;
			if (change_due.size() == 0)
				flag_mismatch("unexpected change word", "none", got);
			else begin
				want = change_due.pop_front();
				if (got !== want)
					flag_mismatch("change word mismatch", show_word(want), got);
			end
			rx_gap = pick_gap(rx_steady);
			if ($urandom_range(0, 29) == 0)
				rx_steady = !rx_steady;
		end else if (rx_gap != 0)
			rx_gap--;
		rsp_if.ready <= arst_n && !hold_off && rx_gap == 0;
	end

	// Long receiver hold-off so the block backs up into its input
	initial begin : rx_hold
		hold_off = 1'b0;
		wait (hold_armed);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog: too long with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Mismatches found");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Stimulus sequence
	initial begin : stimulus
		int ph, k;
		logic [AMT_W-1:0] stock_amt [N_DENOMS];
		stock_amt = '{16'h0102, 16'h0003, 16'hFF05, 16'h000A, 16'h0001,
			16'h0004, 16'h7F02, 16'h0000, 16'hFFFF};
		req_if.valid = 1'b0;
		req_if.mode = MODE_BUY;
		req_if.item_choice = '0;
		req_if.amount = '0;
		req_if.denom_select = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.limit_by_stock = 1'b1;
		limit_on = 1'b1;
		for (k = 0; k < N_DENOMS; k++)
			coins_on_hand[k] = '0;
		for (k = 0; k < N_ARTICLES; k++) begin
			article_price[k] = '0;
			price_plan[k] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: limiting on, stock empty, then loaded
		set_stock_limiting(1'b1);
		queue_word(MODE_BUY, 0, 0, 0);            // exact payment, price zero
		queue_word(MODE_BUY, 5, 777, 0);          // no stock: nothing paid out
		queue_word(MODE_PRICE, 3, 1234, 0);
		queue_word(MODE_PRICE, 15, 65535, 15);
		queue_word(MODE_PRICE, 7, 16'h8000, 9);
		for (k = 0; k < N_DENOMS; k++)
			queue_word(MODE_STOCK, k, stock_amt[k], k);
		queue_word(MODE_STOCK, 0, 50, 9);         // out-of-range stock loads dropped
		queue_word(MODE_STOCK, 0, 65535, 15);
		queue_word(MODE_SPARE, 15, 65535, 15);
		queue_word(MODE_BUY, 3, 1233, 0);         // one cent short
		queue_word(MODE_BUY, 3, 1234, 0);
		queue_word(MODE_BUY, 15, 65535, 15);      // bad start falls back to 500c
		queue_word(MODE_BUY, 0, 65535, 8);        // pennies only, limited by stock
		queue_word(MODE_BUY, 3, 3000, 2);
		queue_word(MODE_BUY, 3, 9999, 5);
		wait_idle();

		// Directed: unlimited change, including the per-denomination cap
		set_stock_limiting(1'b0);
		queue_word(MODE_BUY, 0, 65535, 8);
		queue_word(MODE_BUY, 0, 65535, 0);
		queue_word(MODE_BUY, 15, 65534, 0);
		queue_word(MODE_BUY, 7, 65535, 3);
		wait_idle();

		// Random phases, alternating limiting; one phase runs with the receiver held off
		for (ph = 0; ph < 5; ph++) begin
			set_stock_limiting(ph % 2 == 0);
			if (ph == 1)
				hold_armed = 1'b1;
			for (k = 0; k < PHASE_WORDS; k++)
				queue_random_word();
			wait_idle();
		end

		$display("Ran %0d purchases (%0d underpaid) and %0d load words, %0d change words checked,",
			n_buys, n_under, n_loads, words_checked);
		$display("with stock limiting both on and off and one long receiver stall.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
